/* design/efr_pkg.sv */
// Shared types and constants for the escaped frame receiver.
package efr_pkg;

    localparam int FRAME_CAPACITY = 64;
    localparam int ADDR_W = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;
    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

    localparam logic [7:0] ESC_RESET = 8'd65;
    localparam logic [7:0] BGN_RESET = 8'd66;
    localparam logic [7:0] END_RESET = 8'd67;
    localparam logic [7:0] ZERO_RESET = 8'd68;

    localparam int PADDR_W = 4;

    localparam logic [1:0] REG_ESC = 2'd0;
    localparam logic [1:0] REG_BGN = 2'd1;
    localparam logic [1:0] REG_END = 2'd2;
    localparam logic [1:0] REG_ZERO = 2'd3;

    typedef struct packed {
        logic [7:0] esc_code;
        logic [7:0] bgn_code;
        logic [7:0] end_code;
        logic [7:0] zero_code;
    } codes_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             ovf;
    } close_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_ESC    = 2'd1,
        MODE_ACCEPT = 2'd2
    } parse_mode_t;

    typedef enum logic [1:0] {
        BURST_IDLE = 2'd0,
        BURST_READ = 2'd1,
        BURST_SHOW = 2'd2
    } burst_state_t;

endpackage

/* design/escaped_frame_receiver.sv */
// Top level of the escaped frame receiver: parser, payload store and burst readout.
//
// Input channel (s_valid/s_ready/s_rx_byte): one raw link byte per transfer.
// Escape+begin opens a frame, plain bytes and escape pairs inside it are
// decoded into the payload store, and escape+end closes it.
// Result channel (m_valid/m_ready/m_*): on close the whole stored payload
// leaves as a burst, one transfer per byte, with m_last on the final one.
// An empty frame gives one transfer of length 0 with m_last set.
// s_ready is high whenever no burst runs, so bytes that do not close a frame
// are never held up. A close starts a burst during which s_ready stays low;
// each result needs a store read (BURST_READ) and then shows the registered
// read data (BURST_SHOW) until the receiver takes it; an empty frame goes
// straight to BURST_SHOW. The single read port of the store sets this pace.
// A stalled receiver simply holds the current result; nothing is lost.
// Reset (aresetn low, synchronous) restores the default codes 'A'..'D',
// returns the parser to idle with no frame open and drops any burst.
// Configuration is an APB-style port with the four codes at 0x0..0xC.
module escaped_frame_receiver (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // raw byte input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    // decoded payload output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [7:0]                  m_payload_byte,
    output logic [5:0]                  m_byte_position,
    output logic [6:0]                  m_frame_length,
    output logic                        m_last,
    output logic                        m_overflowed
);

    efr_pkg::codes_t codes;
    efr_pkg::close_t close;

    logic                       byte_fire;
    logic                       wr_en;
    logic [efr_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                 wr_data;
    logic                       rd_en;
    logic [7:0]                 rd_data;

    efr_pkg::burst_state_t      state_reg;
    efr_pkg::burst_state_t      state_next;
    logic [efr_pkg::ADDR_W-1:0] idx_reg;
    logic [efr_pkg::ADDR_W-1:0] idx_next;
    logic [efr_pkg::CNT_W-1:0]  len_reg;
    logic [efr_pkg::CNT_W-1:0]  len_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic                       is_last;
    logic                       out_fire;

    efr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    efr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (byte_fire),
        .rx_byte   (s_rx_byte),
        .codes     (codes),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .close     (close)
    );

    // Payload store: written while a frame is parsed, read only during the burst.
    efr_ram #(
        .WIDTH (8),
        .DEPTH (efr_pkg::FRAME_CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign byte_fire = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;

    // Last result of the burst; an empty frame is its own last result.
    assign is_last = (len_reg == '0) ||
                     ((efr_pkg::CNT_W'(idx_reg) + efr_pkg::CNT_W'(1)) == len_reg);

    // Burst sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            efr_pkg::BURST_IDLE: begin
                if (close.valid) begin
                    state_next = (close.count == '0) ? efr_pkg::BURST_SHOW
                                                     : efr_pkg::BURST_READ;
                end
            end
            efr_pkg::BURST_READ: begin
                state_next = efr_pkg::BURST_SHOW;
            end
            efr_pkg::BURST_SHOW: begin
                if (out_fire) begin
                    state_next = is_last ? efr_pkg::BURST_IDLE : efr_pkg::BURST_READ;
                end
            end
            default: begin
                state_next = efr_pkg::BURST_IDLE;
            end
        endcase
    end

    // Burst sequencer outputs and datapath updates.
    always_comb begin
        s_ready  = (state_reg == efr_pkg::BURST_IDLE);
        m_valid  = (state_reg == efr_pkg::BURST_SHOW);
        rd_en    = (state_reg == efr_pkg::BURST_READ);
        idx_next = idx_reg;
        len_next = len_reg;
        ovf_next = ovf_reg;
        if (state_reg == efr_pkg::BURST_IDLE && close.valid) begin
            // latch the frame summary and restart at the first byte
            idx_next = '0;
            len_next = close.count;
            ovf_next = close.ovf;
        end else if (state_reg == efr_pkg::BURST_SHOW && out_fire && !is_last) begin
            idx_next = idx_reg + efr_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= efr_pkg::BURST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Frame summary needs no reset: only read while a burst is shown.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        len_reg <= len_next;
        ovf_reg <= ovf_next;
    end

    assign m_payload_byte  = (len_reg == '0) ? 8'd0 : rd_data;
    assign m_byte_position = 6'(idx_reg);
    assign m_frame_length  = 7'(len_reg);
    assign m_last          = is_last;
    assign m_overflowed    = ovf_reg;

endmodule

/* design/efr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module efr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/efr_cfg.sv */
// APB-style configuration registers holding the four framing codes.
module efr_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [efr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output efr_pkg::codes_t              codes
);

    efr_pkg::codes_t codes_reg;
    efr_pkg::codes_t codes_next;
    logic            wr_fire;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_fire = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        codes_next = codes_reg;
        if (wr_fire) begin
            case (reg_idx)
                efr_pkg::REG_ESC:  codes_next.esc_code  = pwdata[7:0];
                efr_pkg::REG_BGN:  codes_next.bgn_code  = pwdata[7:0];
                efr_pkg::REG_END:  codes_next.end_code  = pwdata[7:0];
                efr_pkg::REG_ZERO: codes_next.zero_code = pwdata[7:0];
                default:           codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.esc_code  <= efr_pkg::ESC_RESET;
            codes_reg.bgn_code  <= efr_pkg::BGN_RESET;
            codes_reg.end_code  <= efr_pkg::END_RESET;
            codes_reg.zero_code <= efr_pkg::ZERO_RESET;
        end else begin
            codes_reg <= codes_next;
        end
    end

    always_comb begin
        case (reg_idx)
            efr_pkg::REG_ESC:  prdata = {24'd0, codes_reg.esc_code};
            efr_pkg::REG_BGN:  prdata = {24'd0, codes_reg.bgn_code};
            efr_pkg::REG_END:  prdata = {24'd0, codes_reg.end_code};
            efr_pkg::REG_ZERO: prdata = {24'd0, codes_reg.zero_code};
            default:           prdata = 32'd0;
        endcase
    end

    assign codes = codes_reg;

endmodule

/* design/efr_parser.sv */
// Escape-pair parser: tracks frame state and writes payload bytes into the store.
module efr_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_fire,
    input  logic [7:0]                  rx_byte,
    input  efr_pkg::codes_t             codes,
    output logic                        wr_en,
    output logic [efr_pkg::ADDR_W-1:0]  wr_addr,
    output logic [7:0]                  wr_data,
    output efr_pkg::close_t             close
);

    efr_pkg::parse_mode_t mode_reg;
    efr_pkg::parse_mode_t mode_next;
    logic                      open_reg;
    logic                      open_next;
    logic [efr_pkg::CNT_W-1:0] count_reg;
    logic [efr_pkg::CNT_W-1:0] count_next;
    logic                      ovf_reg;
    logic                      ovf_next;

    logic       store_req;
    logic [7:0] store_data;
    logic       open_cmd;
    logic       close_cmd;
    logic       abandon_cmd;
    logic       has_room;
    logic       is_esc;
    logic       is_bgn;
    logic       is_end;
    logic       is_zero;

    assign is_esc  = (rx_byte == codes.esc_code);
    assign is_bgn  = (rx_byte == codes.bgn_code);
    assign is_end  = (rx_byte == codes.end_code);
    assign is_zero = (rx_byte == codes.zero_code);
    assign has_room = (count_reg < efr_pkg::CNT_W'(efr_pkg::FRAME_CAPACITY));

    // Next parse mode; a misplaced code is looked at again as an idle byte.
    always_comb begin
        mode_next = mode_reg;
        if (byte_fire) begin
            case (mode_reg)
                efr_pkg::MODE_ESC: begin
                    if (is_bgn) begin
                        if (!open_reg) begin
                            mode_next = efr_pkg::MODE_ACCEPT;
                        end else begin
                            mode_next = is_esc ? efr_pkg::MODE_ESC : efr_pkg::MODE_IDLE;
                        end
                    end else if (is_end) begin
                        if (open_reg) begin
                            mode_next = efr_pkg::MODE_IDLE;
                        end else begin
                            mode_next = is_esc ? efr_pkg::MODE_ESC : efr_pkg::MODE_IDLE;
                        end
                    end else if (is_esc) begin
                        mode_next = open_reg ? efr_pkg::MODE_ACCEPT : efr_pkg::MODE_ESC;
                    end else if (is_zero) begin
                        mode_next = open_reg ? efr_pkg::MODE_ACCEPT : efr_pkg::MODE_IDLE;
                    end else begin
                        mode_next = efr_pkg::MODE_IDLE;
                    end
                end
                efr_pkg::MODE_ACCEPT: begin
                    if (is_esc) begin
                        mode_next = efr_pkg::MODE_ESC;
                    end
                end
                default: begin
                    mode_next = is_esc ? efr_pkg::MODE_ESC : efr_pkg::MODE_IDLE;
                end
            endcase
        end
    end

    // Actions taken on the accepted byte.
    always_comb begin
        store_req   = 1'b0;
        store_data  = rx_byte;
        open_cmd    = 1'b0;
        close_cmd   = 1'b0;
        abandon_cmd = 1'b0;
        if (byte_fire) begin
            case (mode_reg)
                efr_pkg::MODE_ESC: begin
                    if (is_bgn) begin
                        open_cmd = !open_reg;
                    end else if (is_end) begin
                        close_cmd = open_reg;
                    end else if (is_esc) begin
                        store_req  = open_reg;
                        store_data = codes.esc_code;
                    end else if (is_zero) begin
                        store_req  = open_reg;
                        store_data = 8'd0;
                    end else begin
                        abandon_cmd = 1'b1;
                    end
                end
                efr_pkg::MODE_ACCEPT: begin
                    store_req = !is_esc;
                end
                default: begin
                    store_req = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        open_next  = open_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (open_cmd) begin
            open_next  = 1'b1;
            count_next = '0;
            ovf_next   = 1'b0;
        end else if (close_cmd || abandon_cmd) begin
            open_next = 1'b0;
        end else if (store_req) begin
            if (has_room) begin
                count_next = count_reg + efr_pkg::CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= efr_pkg::MODE_IDLE;
            open_reg  <= 1'b0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            open_reg  <= open_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign wr_en   = store_req && has_room;
    assign wr_addr = count_reg[efr_pkg::ADDR_W-1:0];
    assign wr_data = store_data;

    assign close.valid = close_cmd;
    assign close.count = count_reg;
    assign close.ovf   = ovf_reg;

endmodule

/* tb/efr_frame_checker.sv */
// Frame checker: mirrors the receiver's decoding and compares every payload transfer.
module efr_frame_checker
    import efr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [7:0]          m_payload_byte,
    input  logic [5:0]          m_byte_position,
    input  logic [6:0]          m_frame_length,
    input  logic                m_last,
    input  logic                m_overflowed,
    output int unsigned         err_count,
    output int unsigned         beats_due,
    output int unsigned         bytes_seen,
    output int unsigned         beats_seen,
    output int unsigned         frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] pos;
        logic [6:0] len;
        logic       last;
        logic       ovf;
    } beat_t;

    codes_t           codes;
    parse_mode_t      mode;
    logic             in_frame;
    logic [CNT_W-1:0] stored;
    logic             dropped;
    logic [7:0]       payload [FRAME_CAPACITY];
    beat_t            frame_beats [$];

    task automatic treat_as_idle(input logic [7:0] b);
        if (b == codes.esc_code) begin
            mode = MODE_ESC;
        end else begin
            mode = MODE_IDLE;
        end
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (int'(stored) < FRAME_CAPACITY) begin
            payload[stored[ADDR_W-1:0]] = b;
            stored = stored + CNT_W'(1);
        end else begin
            dropped = 1'b1;
        end
    endtask

    // Queue the burst that a closing pair releases.
    task automatic close_frame();
        beat_t nb;
        frames_seen++;
        if (stored == '0) begin
            nb.data = 8'd0;
            nb.pos  = 6'd0;
            nb.len  = 7'd0;
            nb.last = 1'b1;
            nb.ovf  = dropped;
            frame_beats.push_back(nb);
        end else begin
            for (int i = 0; i < int'(stored); i++) begin
                nb.data = payload[i[ADDR_W-1:0]];
                nb.pos  = i[5:0];
                nb.len  = 7'(stored);
                nb.last = (i == int'(stored) - 1);
                nb.ovf  = dropped;
                frame_beats.push_back(nb);
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        case (mode)
            MODE_ESC: begin
                if (b == codes.bgn_code) begin
                    if (!in_frame) begin
                        in_frame = 1'b1;
                        stored   = '0;
                        dropped  = 1'b0;
                        mode     = MODE_ACCEPT;
                    end else begin
                        treat_as_idle(b);
                    end
                end else if (b == codes.end_code) begin
                    if (in_frame) begin
                        in_frame = 1'b0;
                        mode     = MODE_IDLE;
                        close_frame();
                    end else begin
                        treat_as_idle(b);
                    end
                end else if (b == codes.esc_code) begin
                    if (in_frame) begin
                        keep_byte(codes.esc_code);
                        mode = MODE_ACCEPT;
                    end else begin
                        treat_as_idle(b);
                    end
                end else if (b == codes.zero_code) begin
                    if (in_frame) begin
                        keep_byte(8'd0);
                        mode = MODE_ACCEPT;
                    end else begin
                        treat_as_idle(b);
                    end
                end else begin
                    // unknown code abandons the frame
                    in_frame = 1'b0;
                    mode     = MODE_IDLE;
                end
            end
            MODE_ACCEPT: begin
                if (b == codes.esc_code) begin
                    mode = MODE_ESC;
                end else begin
                    keep_byte(b);
                end
            end
            default: begin
                treat_as_idle(b);
            end
        endcase
    endtask

    task automatic check_beat();
        beat_t want;
        logic  bad;
        beats_seen++;
        if (frame_beats.size() == 0) begin
            $display("%0t: unexpected payload transfer data %0d pos %0d len %0d last %0d ovf %0d",
                     $realtime, m_payload_byte, m_byte_position, m_frame_length, m_last,
                     m_overflowed);
            err_count++;
        end else begin
            want = frame_beats.pop_front();
            bad  = 1'b0;
            if (m_payload_byte !== want.data) begin
                $display("%0t: payload_byte expected %0d got %0d",
                         $realtime, want.data, m_payload_byte);
                bad = 1'b1;
            end
            if (m_byte_position !== want.pos) begin
                $display("%0t: byte_position expected %0d got %0d",
                         $realtime, want.pos, m_byte_position);
                bad = 1'b1;
            end
            if (m_frame_length !== want.len) begin
                $display("%0t: frame_length expected %0d got %0d",
                         $realtime, want.len, m_frame_length);
                bad = 1'b1;
            end
            if (m_last !== want.last) begin
                $display("%0t: last expected %0d got %0d", $realtime, want.last, m_last);
                bad = 1'b1;
            end
            if (m_overflowed !== want.ovf) begin
                $display("%0t: overflowed expected %0d got %0d",
                         $realtime, want.ovf, m_overflowed);
                bad = 1'b1;
            end
            if (bad) begin
                err_count++;
            end
        end
    endtask

    task automatic apb_transfer();
        logic [7:0] held;
        case (paddr[PADDR_W-1:2])
            REG_ESC:  held = codes.esc_code;
            REG_BGN:  held = codes.bgn_code;
            REG_END:  held = codes.end_code;
            default:  held = codes.zero_code;
        endcase
        if (pwrite) begin
            case (paddr[PADDR_W-1:2])
                REG_ESC:  codes.esc_code  = pwdata[7:0];
                REG_BGN:  codes.bgn_code  = pwdata[7:0];
                REG_END:  codes.end_code  = pwdata[7:0];
                default:  codes.zero_code = pwdata[7:0];
            endcase
        end else if (prdata !== {24'd0, held}) begin
            $display("%0t: register read at %0d expected %0d got %0d",
                     $realtime, paddr, held, prdata);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            codes    = {ESC_RESET, BGN_RESET, END_RESET, ZERO_RESET};
            mode     = MODE_IDLE;
            in_frame = 1'b0;
            stored   = '0;
            dropped  = 1'b0;
            frame_beats.delete();
        end else begin
            if (psel && penable && pready) begin
                apb_transfer();
            end
            if (m_valid && m_ready) begin
                check_beat();
            end
            if (s_valid && s_ready) begin
                bytes_seen++;
                decode_byte(s_rx_byte);
            end
        end
        beats_due = frame_beats.size();
    end

endmodule

/* tb/escaped_frame_receiver_tb.sv */
// Top of the escaped frame receiver testbench: stimulus, receiver, watchdog and verdict.
module escaped_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import efr_pkg::*;

    // Cycles without any transfer before the run is declared hung. The longest
    // legal quiet stretch is the deliberate receiver hold below.
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_AT      = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 4;
    localparam int SETTLE_CYCLES = 8;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_payload_byte;
    logic [5:0]         m_byte_position;
    logic [6:0]         m_frame_length;
    logic               m_last;
    logic               m_overflowed;

    int unsigned err_count;
    int unsigned beats_due;
    int unsigned bytes_seen;
    int unsigned beats_seen;
    int unsigned frames_seen;

    // Our copy of the codes, used only to shape the byte stream.
    logic [7:0]  esc_c;
    logic [7:0]  bgn_c;
    logic [7:0]  end_c;
    logic [7:0]  zero_c;

    logic        tx_steady;
    logic        rx_steady;
    logic        noise_mode;
    int unsigned phase_items;
    int unsigned settings_used;
    int unsigned quiet_cycles;

    escaped_frame_receiver dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_byte_position (m_byte_position),
        .m_frame_length  (m_frame_length),
        .m_last          (m_last),
        .m_overflowed    (m_overflowed)
    );

    efr_frame_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload_byte  (m_payload_byte),
        .m_byte_position (m_byte_position),
        .m_frame_length  (m_frame_length),
        .m_last          (m_last),
        .m_overflowed    (m_overflowed),
        .err_count       (err_count),
        .beats_due       (beats_due),
        .bytes_seen      (bytes_seen),
        .beats_seen      (beats_seen),
        .frames_seen     (frames_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // One APB access: setup cycle, then access cycle until pready. Called and
    // returns at a falling edge.
    task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [7:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = {24'd0, value};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write all four codes, then read each back; the checker verifies the reads.
    task automatic set_codes(input logic [7:0] e, input logic [7:0] b,
                             input logic [7:0] n, input logic [7:0] z);
        apb_access(1'b1, REG_ESC, e);
        apb_access(1'b1, REG_BGN, b);
        apb_access(1'b1, REG_END, n);
        apb_access(1'b1, REG_ZERO, z);
        apb_access(1'b0, REG_ESC, 8'd0);
        apb_access(1'b0, REG_BGN, 8'd0);
        apb_access(1'b0, REG_END, 8'd0);
        apb_access(1'b0, REG_ZERO, 8'd0);
        esc_c  = e;
        bgn_c  = b;
        end_c  = n;
        zero_c = z;
        settings_used++;
    endtask

    // Hold the sender until every predicted transfer has arrived, then let
    // the parser finish any byte that produced no result.
    task automatic settle();
        while (beats_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Offer one link byte and hold it until the transfer happens. Returns at
    // the falling edge after acceptance so the next byte can follow at once.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_rx_byte = b;
        s_valid   = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (!noise_mode) begin
            phase_items++;
        end
    endtask

    task automatic send_pair(input logic [7:0] code);
        send_byte(esc_c);
        send_byte(code);
    endtask

    // Any byte value except the escape code travels as a plain payload byte.
    function automatic logic [7:0] pick_plain();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == esc_c) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    // Mix plain bytes with escaped literals and escaped zeros.
    task automatic send_payload(input int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                send_pair(esc_c);
            end else if (pick == 1) begin
                send_pair(zero_c);
            end else begin
                send_byte(pick_plain());
            end
        end
    endtask

    task automatic send_random_sequence();
        int unsigned kind;
        int unsigned len;
        tx_steady = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        if (kind < 55) begin
            // well-formed frame
            send_pair(bgn_c);
            send_payload(len);
            send_pair(end_c);
        end else if (kind < 70) begin
            // frame that an arbitrary byte after an escape may cut short
            send_pair(bgn_c);
            send_payload(len % 6);
            send_pair(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            case ($urandom_range(0, 2))
                0: begin
                    send_pair(end_c);
                    send_pair(zero_c);
                end
                1: begin
                    // begin inside an open frame, then close from idle
                    send_pair(bgn_c);
                    send_payload(len % 4);
                    send_pair(bgn_c);
                    send_byte(pick_plain());
                    send_pair(end_c);
                end
                default: begin
                    send_byte(esc_c);
                    send_pair(bgn_c);
                    send_payload(len % 5);
                    send_pair(end_c);
                end
            endcase
        end else begin
            // line noise; not counted as meaningful stimulus
            noise_mode = 1'b1;
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            noise_mode = 1'b0;
        end
    endtask

    task automatic run_random_phase();
        phase_items = 0;
        while (phase_items < PHASE_ITEMS) send_random_sequence();
    endtask

    // Receiver: random ready gaps with steady stretches, and one long hold
    // inside the over-capacity burst so the block holds its result and keeps s_ready low.
    initial begin
        int unsigned gap;
        int unsigned taken;
        m_ready   = 1'b0;
        rx_steady = 1'b0;
        taken     = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (taken % 16 == 0) begin
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            gap = rx_steady ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            taken++;
            if (taken == HOLD_AT) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
        end
    end

    // Watchdog: any transfer on any port restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_rx_byte     = 8'd0;
        tx_steady     = 1'b0;
        noise_mode    = 1'b0;
        phase_items   = 0;
        settings_used = 1;
        quiet_cycles  = 0;
        esc_c         = ESC_RESET;
        bgn_c         = BGN_RESET;
        end_c         = END_RESET;
        zero_c        = ZERO_RESET;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part at the reset codes.
        tx_steady = 1'($urandom_range(0, 1));
        send_byte(8'h00);          // idle bytes are dropped
        send_byte(8'hFF);
        send_pair(end_c);          // close with no frame: end is looked at again in idle
        send_pair(zero_c);         // zero with no frame
        send_byte(esc_c);          // escape escape with no frame leaves the parser escaped
        send_pair(bgn_c);          // ... so this begin opens the frame
        send_byte(8'h00);
        send_byte(8'hFF);
        send_pair(esc_c);          // literal escape byte
        send_pair(zero_c);         // stored zero
        send_byte(bgn_c);          // begin code as plain payload
        send_pair(end_c);
        send_pair(bgn_c);          // empty frame
        send_pair(end_c);
        send_pair(bgn_c);
        send_byte(8'h5A);
        send_pair(bgn_c);          // begin inside a frame: idle, frame stays open
        send_byte(8'h33);          // dropped while idle
        send_pair(8'h11);          // unknown code abandons the frame

        // Over-capacity frame: fills the store to the top and sets the flag.
        tx_steady = 1'b0;
        send_pair(bgn_c);
        repeat (FRAME_CAPACITY + 2) send_byte(pick_plain());
        send_pair(end_c);
        run_random_phase();

        // Extreme code values.
        s_valid = 1'b0;
        settle();
        set_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
        run_random_phase();

        // Equal codes: begin shadows end, escape shadows zero.
        s_valid = 1'b0;
        settle();
        set_codes(8'hFF, 8'h00, 8'h00, 8'hFF);
        run_random_phase();

        // Arbitrary codes, collisions allowed.
        s_valid = 1'b0;
        settle();
        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_phase();

        // Drain and let any trailing work finish.
        s_valid = 1'b0;
        while (beats_due != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("Covered %0d link bytes and %0d payload transfers from %0d closed frames",
                 bytes_seen, beats_seen, frames_seen);
        $display("across %0d code settings, including an over-capacity frame and a long hold.",
                 settings_used);
        if (err_count == 0 && beats_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d transfers never arrived", err_count, beats_due);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
